// File: hw/rtl/svt_pkg.sv
// Shared types and constants for the satellite view table.
// Used by svt_ctrl, svt_datapath, satellite_view_table, svt_checker and tb_top; no dependencies.
package svt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 32;

	localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

	localparam logic [7:0] PRN_MIN   = 8'd1;
	localparam logic [7:0] PRN_LIMIT = 8'd200;
	localparam logic [7:0] QZSS_MIN  = 8'd193;
	localparam logic [7:0] QZSS_MAX  = 8'd199;

	localparam logic [7:0] ELEV_MAX = 8'd90;
	localparam logic [8:0] AZ_LIMIT = 9'd360;

	localparam logic [2:0] KIND_MAX  = 3'd4;
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_QZSS = 3'd5;

	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_PURGE  = 1'b1;

	localparam logic [5:0] PURGED_SAT = 6'h3F;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;  // latch the input word, clear the walk
		logic issue;  // read the next table entry
		logic eval;   // act on the entry read last cycle
		logic load;   // move the result into the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic stop;      // walk finished this cycle
		logic out_free;  // output register can take a result
	} ctrl_stat_t;

	typedef struct packed {
		logic [7:0]  number;
		logic [6:0]  elevation;
		logic [8:0]  azimuth;
		logic [7:0]  snr;
		logic [2:0]  kind;
		logic [31:0] last_heard;
	} entry_t;

endpackage

// File: hw/rtl/svt_ctrl.sv
// Controller for the satellite view table: idle, walk, result hand-off.
// Depends on svt_pkg.
module svt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  svt_pkg::ctrl_stat_t stat,
	output svt_pkg::ctrl_cmd_t  cmd
);
	import svt_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.stop) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				cmd.eval  = 1'b1;
			end
			ST_DONE: begin
				cmd.load = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: hw/rtl/svt_datapath.sv
// Datapath for the satellite view table: entry memory, walk pointer,
// match and stale checks, result and output registers. Depends on svt_pkg.
module svt_datapath #(
	parameter int unsigned TABLE_ENTRIES = svt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  svt_pkg::ctrl_cmd_t  cmd,
	output svt_pkg::ctrl_stat_t stat,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_cmd,
	input  logic [7:0]         in_prn,
	input  logic signed [8:0]  in_elevation,
	input  logic signed [9:0]  in_azimuth,
	input  logic signed [8:0]  in_snr,
	input  logic [2:0]         in_constellation,
	input  logic [31:0]        in_now_ms,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [4:0]         out_slot,
	output logic               out_written,
	output logic [5:0]         out_purged
);
	import svt_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	logic [31:0] timeout_q;

	logic              cmd_q;
	logic [7:0]        prn_q;
	logic [8:0]        elev_q;
	logic [9:0]        az_q;
	logic [8:0]        snr_q;
	logic [2:0]        con_q;
	logic [31:0]       now_q;

	entry_t            mem_q [TABLE_ENTRIES];
	logic              init_q [TABLE_ENTRIES];

	logic [IDX_W-1:0]  rd_idx_q;
	logic              rd_done_q;

	entry_t            entry_s1;
	logic              init_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              act_s1;

	logic [IDX_W-1:0]  slot_q;
	logic              written_q;
	logic [5:0]        purged_q;

	logic              out_valid_q;
	logic [4:0]        out_slot_q;
	logic              out_written_q;
	logic [5:0]        out_purged_q;

	entry_t            base;
	entry_t            wr_entry;
	logic              occupied;
	logic              prn_ok;
	logic              is_qzss;
	logic [31:0]       age;
	logic              hit;
	logic              stale;
	logic              last_s1;
	logic              wr_en;
	logic [IDX_W+4:0]  slot_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q  <= in_cmd;
			prn_q  <= in_prn;
			elev_q <= in_elevation;
			az_q   <= in_azimuth;
			snr_q  <= in_snr;
			con_q  <= in_constellation;
			now_q  <= in_now_ms;
		end
	end

	// Entry evaluation; a never-written entry reads as all zero.
	always_comb begin
		base     = init_s1 ? entry_s1 : '0;
		occupied = init_s1 && (entry_s1.number != '0);
		prn_ok   = (prn_q >= PRN_MIN) && (prn_q < PRN_LIMIT);
		is_qzss  = (prn_q >= QZSS_MIN) && (prn_q <= QZSS_MAX);
		age      = now_q - base.last_heard;
		last_s1  = (idx_s1 == IDX_LAST);
		hit      = cmd.eval && act_s1 && (cmd_q == CMD_REPORT) && prn_ok
			&& (!occupied || (base.number == prn_q));
		stale    = cmd.eval && act_s1 && (cmd_q == CMD_PURGE) && occupied
			&& (age > timeout_q);
		wr_en    = hit || stale;

		wr_entry = base;
		if (stale) begin
			wr_entry.number = '0;
		end else begin
			wr_entry.number     = prn_q;
			wr_entry.last_heard = now_q;
			if (!elev_q[8] && (elev_q[7:0] <= ELEV_MAX)) begin
				wr_entry.elevation = elev_q[6:0];
			end
			if (!az_q[9] && (az_q[8:0] < AZ_LIMIT)) begin
				wr_entry.azimuth = az_q[8:0];
			end
			if (!snr_q[8]) begin
				wr_entry.snr = snr_q[7:0];
			end
			if (is_qzss) begin
				wr_entry.kind = KIND_QZSS;
			end else if (con_q <= KIND_MAX) begin
				wr_entry.kind = con_q;
			end else begin
				wr_entry.kind = KIND_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			entry_s1 <= mem_q[rd_idx_q];
		end
		if (wr_en) begin
			mem_q[idx_s1] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				init_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			init_q[idx_s1] <= 1'b1;
		end
	end

	// Walk pointer and read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_done_q <= 1'b0;
			act_s1    <= 1'b0;
			idx_s1    <= '0;
			init_s1   <= 1'b0;
		end else if (cmd.start) begin
			rd_idx_q  <= '0;
			rd_done_q <= 1'b0;
			act_s1    <= 1'b0;
		end else begin
			act_s1 <= cmd.issue && !rd_done_q;
			if (cmd.issue) begin
				idx_s1  <= rd_idx_q;
				init_s1 <= init_q[rd_idx_q];
			end
			if (cmd.issue && !rd_done_q) begin
				if (rd_idx_q == IDX_LAST) begin
					rd_done_q <= 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			written_q <= 1'b0;
			purged_q  <= '0;
		end else if (cmd.start) begin
			slot_q    <= '0;
			written_q <= 1'b0;
			purged_q  <= '0;
		end else begin
			if (hit) begin
				slot_q    <= idx_s1;
				written_q <= 1'b1;
			end
			if (stale && (purged_q != PURGED_SAT)) begin
				purged_q <= purged_q + 1'b1;
			end
		end
	end

	assign slot_ext = (IDX_W + 5)'(slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_slot_q    <= slot_ext[4:0];
			out_written_q <= written_q;
			out_purged_q  <= purged_q;
		end
	end

	assign stat.stop     = cmd.eval && act_s1 && (hit || last_s1);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_slot    = out_slot_q;
	assign out_written = out_written_q;
	assign out_purged  = out_purged_q;

endmodule

// File: hw/rtl/satellite_view_table.sv
// Satellite view table, top level: joins the controller and the datapath.
// Depends on svt_pkg, svt_ctrl and svt_datapath.
//
// Keeps up to TABLE_ENTRIES satellites in view. Each input word is either a
// satellite report (cmd 0) or a purge (cmd 1), and each gives exactly one
// result word. A report with PRN 1 to 199 lands in the first entry that holds
// that PRN or is empty; with no such entry, or with any other PRN, nothing is
// stored and the result reads slot 0, written 0. Elevation 0..90, azimuth
// 0..359 and a non-negative SNR replace the stored values; absent or
// out-of-range values keep the old ones. PRN 193..199 is stored as kind QZSS
// (5), constellation codes 5..7 as unknown (0). A purge empties every occupied
// entry whose age (now_ms minus last heard, modulo 2^32) is strictly above
// stale_timeout_ms and reports how many it emptied, saturating at 63.
// stale_timeout_ms resets to 30000 and is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle: the block does not
// enforce this. Timing: one item at a time; the controller walks the entry
// memory through its single read port, one entry per cycle with the read
// data registered. A walk visits the entries up to the matching one for a
// stored report and all TABLE_ENTRIES for a purge or a dropped report; the
// result then waits until the output register is free. The next word is
// taken as soon as the result is in the output register, even if it is not
// yet consumed.
// The table is empty right after reset; no clearing pass is run.
module satellite_view_table #(
	parameter int unsigned TABLE_ENTRIES = svt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        prn,
	input  logic signed [8:0] elevation,
	input  logic signed [9:0] azimuth,
	input  logic signed [8:0] snr,
	input  logic [2:0]        constellation,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [4:0]        slot,
	output logic              written,
	output logic [5:0]        purged
);
	import svt_pkg::*;

	ctrl_cmd_t  ctrl_cmd;
	ctrl_stat_t ctrl_stat;

	// Controller: idle, walk the table, hand the result to the output word.
	svt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (ctrl_stat),
		.cmd      (ctrl_cmd)
	);

	// Datapath: entry memory, match and age checks, output register.
	svt_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (ctrl_cmd),
		.stat             (ctrl_stat),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_cmd           (cmd),
		.in_prn           (prn),
		.in_elevation     (elevation),
		.in_azimuth       (azimuth),
		.in_snr           (snr),
		.in_constellation (constellation),
		.in_now_ms        (now_ms),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.out_slot         (slot),
		.out_written      (written),
		.out_purged       (purged)
	);

	// Hold off new words for the cycle after an acceptance: the walk has begun.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a walk was starting");

	// A result never reports both a stored report and purged entries.
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(written && (purged != 6'd0)))
		else $error("result mixes report and purge");

	// A new result word is loaded only as the controller returns to idle.
	a_load_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result loaded while controller busy");

	// A result with nothing stored (a dropped report or a purge) keeps slot at zero.
	a_drop_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !written |-> (slot == 5'd0))
		else $error("nonzero slot on a word with nothing stored");

endmodule

// File: tb/svt_checker.sv
// Result checker for the satellite view table: watches both word channels and
// the timeout register, predicts each result from its own table and compares.
// Depends on svt_pkg.
module svt_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        prn,
	input  logic signed [8:0] elevation,
	input  logic signed [9:0] azimuth,
	input  logic signed [8:0] snr,
	input  logic [2:0]        constellation,
	input  logic [31:0]       now_ms,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [4:0]        slot,
	input  logic              written,
	input  logic [5:0]        purged,
	output int unsigned       mismatches,
	output int unsigned       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import svt_pkg::*;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  prn;
		logic [8:0]  elevation;
		logic [9:0]  azimuth;
		logic [8:0]  snr;
		logic [2:0]  constellation;
		logic [31:0] now_ms;
	} sat_word_t;

	typedef struct packed {
		logic [4:0] slot;
		logic       written;
		logic [5:0] purged;
	} sat_result_t;

	entry_t      sat_table [TABLE_ENTRIES_DEF];
	logic [31:0] stale_limit;
	sat_result_t results_due [$];
	int unsigned results_seen;

	// Apply one word to the table copy and return the result it gives.
	function automatic sat_result_t table_update(input sat_word_t w);
		sat_result_t r;
		logic        found;
		logic [31:0] age;
		r = '0;
		found = 1'b0;
		if (w.cmd == CMD_PURGE) begin
			for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
				age = w.now_ms - sat_table[i].last_heard;
				if (sat_table[i].number != '0 && age > stale_limit) begin
					sat_table[i].number = '0;
					if (r.purged != PURGED_SAT)
						r.purged++;
				end
			end
		end else if (w.prn >= PRN_MIN && w.prn < PRN_LIMIT) begin
			for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
				if (!found && (sat_table[i].number == w.prn || sat_table[i].number == '0)) begin
					found = 1'b1;
					sat_table[i].number = w.prn;
					if (!w.elevation[8] && w.elevation[7:0] <= ELEV_MAX)
						sat_table[i].elevation = w.elevation[6:0];
					if (!w.azimuth[9] && w.azimuth[8:0] < AZ_LIMIT)
						sat_table[i].azimuth = w.azimuth[8:0];
					// a clear sign bit leaves at most 255, so no clamp is needed
					if (!w.snr[8])
						sat_table[i].snr = w.snr[7:0];
					sat_table[i].kind = (w.constellation <= KIND_MAX) ? w.constellation : KIND_NONE;
					if (w.prn >= QZSS_MIN && w.prn <= QZSS_MAX)
						sat_table[i].kind = KIND_QZSS;
					sat_table[i].last_heard = w.now_ms;
					r.slot = 5'(i);
					r.written = 1'b1;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sat_result_t want;
		if (!arst_n) begin
			foreach (sat_table[i])
				sat_table[i] = '0;
			stale_limit = TIMEOUT_RESET;
			results_due.delete();
			results_seen = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			// retire a result first: it always belongs to an older word
			if (out_valid && out_ready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t result %0d with no word pending: slot %0d written %0d purged %0d",
							$realtime, results_seen, slot, written, purged);
				end else begin
					want = results_due.pop_front();
					if (slot !== want.slot || written !== want.written || purged !== want.purged) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t result %0d: expected slot %0d written %0d purged %0d, got slot %0d written %0d purged %0d",
								$realtime, results_seen, want.slot, want.written, want.purged,
								slot, written, purged);
					end
				end
			end
			if (cfg_we)
				stale_limit = cfg_wdata;
			if (in_valid && in_ready)
				results_due.push_back(table_update('{cmd, prn, elevation, azimuth, snr,
					constellation, now_ms}));
			pending = results_due.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the satellite view table testbench: clock, reset, word stimulus and
// the verdict. Depends on svt_pkg, satellite_view_table and svt_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import svt_pkg::*;

	// Constellation codes as the talker id gives them; 5..7 are unassigned.
	localparam logic [2:0] CON_UNKNOWN = 3'd0;
	localparam logic [2:0] CON_GPS     = 3'd1;
	localparam logic [2:0] CON_GLONASS = 3'd2;
	localparam logic [2:0] CON_GALILEO = 3'd3;
	localparam logic [2:0] CON_BEIDOU  = 3'd4;
	localparam logic [2:0] CON_RSVD5   = 3'd5;
	localparam logic [2:0] CON_RSVD6   = 3'd6;
	localparam logic [2:0] CON_RSVD7   = 3'd7;

	// Most reports draw from a pool a bit larger than the table, so entries get
	// revisited often and the table still runs full.
	localparam int unsigned PRN_POOL = 40;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [31:0]       cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic              cmd;
	logic [7:0]        prn;
	logic signed [8:0] elevation;
	logic signed [9:0] azimuth;
	logic signed [8:0] snr;
	logic [2:0]        constellation;
	logic [31:0]       now_ms;
	logic              out_valid;
	logic              out_ready;
	logic [4:0]        slot;
	logic              written;
	logic [5:0]        purged;

	int unsigned mismatches;
	int unsigned pending;

	int          burst_left;   // words left in the current sender burst
	logic [31:0] sim_ms;       // receiver time stamp carried from word to word
	logic        squeeze_req;  // ask the receiver for one long hold-off
	logic        squeeze_done;

	satellite_view_table i_dut (.*);

	svt_checker i_checker (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard stop: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Offer one word at the falling edge and hold it until the block takes it.
	// Keep valid high across a burst; at the end of a burst drop it for a
	// random gap, or carry straight on so that stretches without idling occur.
	task automatic offer(input logic c, input logic [7:0] p, input logic signed [8:0] el,
			input logic signed [9:0] az, input logic signed [8:0] sn, input logic [2:0] con,
			input logic [31:0] t);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		cmd = c;
		prn = p;
		elevation = el;
		azimuth = az;
		snr = sn;
		constellation = con;
		now_ms = t;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	// Drop valid and wait until every accepted word has its result back; each
	// word gives exactly one result, so the block is idle after that.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_timeout(input logic [31:0] value);
		settle();
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// One random phase at a given timeout. step_max sets how fast time runs
	// against the timeout, so that purges find a mix of fresh and stale entries.
	task automatic run_phase(input logic [31:0] limit, input int unsigned step_max,
			input int unsigned count);
		int unsigned       pick;
		logic              c;
		logic [7:0]        p;
		logic signed [8:0] el;
		logic signed [9:0] az;
		logic signed [8:0] sn;
		set_timeout(limit);
		repeat (count) begin
			// advance time, with the odd jump anywhere (backwards or across the wrap)
			if ($urandom_range(0, 99) < 3)
				sim_ms = $urandom();
			else
				sim_ms += $urandom_range(0, step_max);
			c = ($urandom_range(0, 99) < 12) ? CMD_PURGE : CMD_REPORT;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				p = 8'($urandom_range(1, PRN_POOL));
			else if (pick < 80)
				p = 8'($urandom_range(PRN_MIN, PRN_LIMIT - 1));
			else if (pick < 88)
				p = 8'($urandom_range(QZSS_MIN, QZSS_MAX));
			else if (pick < 95)
				p = 8'($urandom_range(PRN_LIMIT, 255));
			else
				p = '0;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				el = 9'($urandom_range(0, ELEV_MAX));
			else if (pick < 80)
				el = -1;
			else if (pick < 90)
				el = 9'($urandom_range(ELEV_MAX + 1, 255));
			else
				el = 9'($urandom());
			pick = $urandom_range(0, 99);
			if (pick < 70)
				az = 10'($urandom_range(0, AZ_LIMIT - 1));
			else if (pick < 80)
				az = -1;
			else if (pick < 90)
				az = 10'($urandom_range(AZ_LIMIT, 511));
			else
				az = 10'($urandom());
			pick = $urandom_range(0, 99);
			if (pick < 75)
				sn = 9'($urandom_range(0, 255));
			else if (pick < 85)
				sn = -1;
			else
				sn = 9'($urandom());
			offer(c, p, el, az, sn, 3'($urandom_range(0, 7)), sim_ms);
		end
	endtask

	// Receiver: cycle through segments of always ready, coin-flip ready and a
	// sparse periodic pattern. Once asked, hold off for a long stretch so the
	// output register and the word behind it fill and in_ready drops; now and
	// then take another long hold unasked.
	initial begin
		int len;
		int mode;
		int period;
		out_ready = 1'b0;
		squeeze_done = 1'b0;
		forever begin
			if ((squeeze_req && !squeeze_done) || $urandom_range(0, 59) == 0) begin
				squeeze_done = squeeze_req;
				repeat (500) begin
					@(negedge clk);
					out_ready = 1'b0;
				end
			end else begin
				mode = $urandom_range(0, 2);
				len = $urandom_range(20, 200);
				period = $urandom_range(2, 5);
				for (int i = 0; i < len; i++) begin
					@(negedge clk);
					case (mode)
						0: begin
							out_ready = 1'b1;
						end
						1: begin
							out_ready = 1'($urandom_range(0, 1));
						end
						default: begin
							out_ready = (i % period) == 0;
						end
					endcase
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cmd = CMD_REPORT;
		prn = '0;
		elevation = '0;
		azimuth = '0;
		snr = '0;
		constellation = CON_UNKNOWN;
		now_ms = '0;
		squeeze_req = 1'b0;
		burst_left = $urandom_range(1, 30);
		sim_ms = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed words at the reset timeout of 30000 ms.
		// Fill the first entries; cover the range limits, QZSS and unassigned codes.
		offer(CMD_REPORT, 8'd1,   0,   0,   0,   CON_GPS,     32'd1000);
		offer(CMD_REPORT, 8'd199, 90,  359, 255, CON_RSVD7,   32'd1000);
		offer(CMD_REPORT, 8'd193, 45,  180, 30,  CON_RSVD5,   32'd1000);
		offer(CMD_REPORT, 8'd192, 10,  20,  40,  CON_RSVD6,   32'd1000);
		// Invalid PRNs: zero, first one above the range, and the saturated value.
		offer(CMD_REPORT, 8'd0,   10,  10,  10,  CON_GPS,     32'd1000);
		offer(CMD_REPORT, 8'd200, 10,  10,  10,  CON_GPS,     32'd1000);
		offer(CMD_REPORT, 8'd255, 10,  10,  10,  CON_GPS,     32'd1000);
		// Update PRN 1 in place: absent fields, out-of-range fields, field maxima; then store PRN 2.
		offer(CMD_REPORT, 8'd1,   -1,  -1,  -1,  CON_GLONASS, 32'd2000);
		offer(CMD_REPORT, 8'd1,   91,  360, -256, CON_GALILEO, 32'd2000);
		offer(CMD_REPORT, 8'd1,   255, 511, 255, CON_BEIDOU,  32'd2000);
		offer(CMD_REPORT, 8'd2,   -256, -512, 17, CON_UNKNOWN, 32'd2000);
		// Purge with nothing stale, then age exactly at the timeout (kept) for
		// PRN 1 and 2 while the three older entries go, then one ms later.
		offer(CMD_PURGE,  8'd0,   0,   0,   0,   CON_UNKNOWN, 32'd2000);
		offer(CMD_PURGE,  8'd0,   0,   0,   0,   CON_UNKNOWN, 32'd32000);
		offer(CMD_PURGE,  8'd0,   0,   0,   0,   CON_UNKNOWN, 32'd32001);
		// Reuse the first empty entry; then time goes back, so the age wraps huge.
		offer(CMD_REPORT, 8'd7,   30,  30,  30,  CON_GPS,     32'd32001);
		offer(CMD_PURGE,  8'd0,   0,   0,   0,   CON_UNKNOWN, 32'd0);
		// Stamp just below the wrap and purge just after it: small age, kept.
		offer(CMD_REPORT, 8'd150, 60,  60,  60,  CON_GALILEO, 32'hFFFF_FF00);
		offer(CMD_PURGE,  8'd0,   0,   0,   0,   CON_UNKNOWN, 32'h0000_0010);
		sim_ms = 32'h0000_0010;

		// Random phases over a range of timeouts, the extremes among them. The
		// largest timeout never purges, so the table runs full early on.
		squeeze_req = 1'b1;
		run_phase(32'hFFFF_FFFF, 1 << 26, 250);
		run_phase(32'd0, 2, 250);
		run_phase(32'd50, 40, 250);
		run_phase(TIMEOUT_RESET, 8000, 250);
		begin
			logic [31:0] t;
			t = $urandom_range(1000, 2_000_000);
			run_phase(t, t / 6, 250);
		end
		run_phase(32'd1, 2, 250);

		// Drain, then give a stray result time to show up.
		settle();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
